/* design/ilst_pkg.sv */
// shared codes, field widths and control structs for the indexed list store
`default_nettype none
package ilst_pkg;

  // fixed field widths of the request and result channels
  localparam int OP_W     = 3;
  localparam int INDEX_W  = 7;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  // operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_GET    = 3'd2;
  localparam logic [OP_W-1:0] OP_SET    = 3'd3;
  localparam logic [OP_W-1:0] OP_POP    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

  // commands from controller to datapath
  typedef struct packed {
    logic load;         // latch an accepted request
    logic ptr_init;     // start the shift pointer
    logic read_target;  // read the addressed or last entry
    logic capture;      // keep the read word
    logic shift_rd;     // read the neighbor of the pointer
    logic shift_wr;     // write the neighbor word at the pointer
    logic write_value;  // write the request word at the index
    logic finish;       // commit count and load the result register
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            err;        // request refused
    logic            at_end;     // insert index equals count
    logic            ptr_last;   // pointer sits on the last live entry
    logic            step_done;  // this shift write is the last one
    logic            out_free;   // result register can take a result
  } stat_t;

endpackage
`default_nettype wire

/* design/ilst_req_if.sv */
// request channel: operation, index and word with valid/ready
`default_nettype none
interface ilst_req_if;
  logic                          valid;
  logic                          ready;
  logic [ilst_pkg::OP_W-1:0]     op;
  logic [ilst_pkg::INDEX_W-1:0]  index;
  logic [ilst_pkg::VALUE_W-1:0]  value;

  modport source (output valid, output op, output index, output value, input ready);
  modport sink   (input valid, input op, input index, input value, output ready);
endinterface
`default_nettype wire

/* design/ilst_rsp_if.sv */
// result channel: read word, status and count with valid/ready
`default_nettype none
interface ilst_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ilst_pkg::VALUE_W-1:0]  read_value;
  logic [ilst_pkg::STATUS_W-1:0] status;
  logic [ilst_pkg::COUNT_W-1:0]  count;

  modport source (output valid, output read_value, output status, output count,
                  input ready);
  modport sink   (input valid, input read_value, input status, input count,
                  output ready);
endinterface
`default_nettype wire

/* design/ilst_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none
module ilst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* design/ilst_ctrl.sv */
// controller state machine sequencing checks, reads and entry shifts
`default_nettype none
module ilst_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire ilst_pkg::stat_t stat,
  output ilst_pkg::cmd_t     cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_CHECK  = 3'd1;
  localparam logic [2:0] S_READ   = 3'd2;
  localparam logic [2:0] S_CAPT   = 3'd3;
  localparam logic [2:0] S_SH_RD  = 3'd4;
  localparam logic [2:0] S_SH_WR  = 3'd5;
  localparam logic [2:0] S_WRITE  = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state;
  logic [2:0] state_next;

  // no request is taken while reset is held
  assign req_ready = !rst && (state == S_IDLE);

  // next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd.ptr_init = 1'b1;
        if (stat.err) begin
          state_next = S_FINISH;
        end else begin
          case (stat.op)
            ilst_pkg::OP_INSERT: state_next = stat.at_end ? S_WRITE : S_SH_RD;
            ilst_pkg::OP_REMOVE: state_next = S_READ;
            ilst_pkg::OP_GET:    state_next = S_READ;
            ilst_pkg::OP_POP:    state_next = S_READ;
            ilst_pkg::OP_SET:    state_next = S_WRITE;
            default:             state_next = S_FINISH;
          endcase
        end
      end
      S_READ: begin
        cmd.read_target = 1'b1;
        state_next      = S_CAPT;
      end
      S_CAPT: begin
        cmd.capture = 1'b1;
        if (stat.op == ilst_pkg::OP_REMOVE && !stat.ptr_last) begin
          state_next = S_SH_RD;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_SH_RD: begin
        cmd.shift_rd = 1'b1;
        state_next   = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.shift_wr = 1'b1;
        if (stat.step_done) begin
          state_next = (stat.op == ilst_pkg::OP_INSERT) ? S_WRITE : S_FINISH;
        end else begin
          state_next = S_SH_RD;
        end
      end
      S_WRITE: begin
        cmd.write_value = 1'b1;
        state_next      = S_FINISH;
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

/* design/ilst_dpath.sv */
// datapath: request registers, count, shift pointer, entry ram and result register
`default_nettype none
module ilst_dpath #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire ilst_pkg::cmd_t                   cmd,
  output ilst_pkg::stat_t                       stat,
  input  wire logic [ilst_pkg::OP_W-1:0]        req_op,
  input  wire logic [ilst_pkg::INDEX_W-1:0]     req_index,
  input  wire logic [ilst_pkg::VALUE_W-1:0]     req_value,
  output logic                                  rsp_valid,
  input  wire logic                             rsp_ready,
  output logic      [ilst_pkg::VALUE_W-1:0]     rsp_read_value,
  output logic      [ilst_pkg::STATUS_W-1:0]    rsp_status,
  output logic      [ilst_pkg::COUNT_W-1:0]     rsp_count
);

  localparam int AW   = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);
  localparam int CMPW = (CNTW > ilst_pkg::INDEX_W) ? CNTW : ilst_pkg::INDEX_W;
  localparam int CW   = (WORD_WIDTH > ilst_pkg::VALUE_W) ? WORD_WIDTH : ilst_pkg::VALUE_W;
  localparam int OCW  = (CNTW > ilst_pkg::COUNT_W) ? CNTW : ilst_pkg::COUNT_W;

  logic [ilst_pkg::OP_W-1:0]     op_q;
  logic [ilst_pkg::INDEX_W-1:0]  index_q;
  logic [WORD_WIDTH-1:0]         value_q;
  logic [CNTW-1:0]               count;
  logic [CNTW-1:0]               ptr;
  logic [WORD_WIDTH-1:0]         rd;

  logic [CW-1:0]                 value_ext;
  logic [CW-1:0]                 rd_ext;
  logic [CMPW-1:0]               idx_c;
  logic [CMPW-1:0]               cnt_c;
  logic [CNTW-1:0]               idx_n;
  logic [CNTW-1:0]               cnt_m1;
  logic [CNTW-1:0]               ptr_inc;
  logic [CNTW-1:0]               ptr_dec;
  logic [OCW-1:0]                count_out;
  logic [CNTW-1:0]               count_new;
  logic                          full;
  logic [ilst_pkg::STATUS_W-1:0] status_c;
  logic                          has_read;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [WORD_WIDTH-1:0]         ram_wdata;
  logic [AW-1:0]                 ram_raddr;
  logic [WORD_WIDTH-1:0]         ram_rdata;

  // width adaptation of the request word
  assign value_ext = CW'(req_value);

  // request registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q    <= req_op;
      index_q <= req_index;
      value_q <= value_ext[WORD_WIDTH-1:0];
    end
  end

  // compare views of index and count
  assign idx_c   = CMPW'(index_q);
  assign cnt_c   = CMPW'(count);
  assign idx_n   = idx_c[CNTW-1:0];
  assign cnt_m1  = count - CNTW'(1);
  assign ptr_inc = ptr + CNTW'(1);
  assign ptr_dec = ptr - CNTW'(1);
  assign full    = (count == CNTW'(CAPACITY));

  // request checks
  always_comb begin
    status_c = ilst_pkg::ST_OK;
    case (op_q)
      ilst_pkg::OP_INSERT: begin
        if (full) begin
          status_c = ilst_pkg::ST_FULL;
        end else if (idx_c > cnt_c) begin
          status_c = ilst_pkg::ST_RANGE;
        end
      end
      ilst_pkg::OP_REMOVE, ilst_pkg::OP_GET, ilst_pkg::OP_SET: begin
        if (idx_c >= cnt_c) begin
          status_c = ilst_pkg::ST_RANGE;
        end
      end
      ilst_pkg::OP_POP: begin
        if (count == '0) begin
          status_c = ilst_pkg::ST_EMPTY;
        end
      end
      default: begin
        status_c = ilst_pkg::ST_OK;
      end
    endcase
  end

  // status to controller
  always_comb begin
    stat.op        = op_q;
    stat.err       = (status_c != ilst_pkg::ST_OK);
    stat.at_end    = (idx_c == cnt_c);
    stat.ptr_last  = (ptr == cnt_m1);
    stat.step_done = (op_q == ilst_pkg::OP_INSERT) ? (ptr_dec == idx_n) : (ptr_inc == cnt_m1);
    stat.out_free  = !rsp_valid || rsp_ready;
  end

  // shift pointer: insert walks down from count, remove walks up from index
  always_ff @(posedge clk) begin
    if (cmd.ptr_init) begin
      ptr <= (op_q == ilst_pkg::OP_INSERT) ? count : idx_n;
    end else if (cmd.shift_wr) begin
      ptr <= (op_q == ilst_pkg::OP_INSERT) ? ptr_dec : ptr_inc;
    end
  end

  // ram address and data selection
  always_comb begin
    ram_raddr = ptr[AW-1:0];
    if (cmd.read_target) begin
      ram_raddr = (op_q == ilst_pkg::OP_POP) ? cnt_m1[AW-1:0] : idx_c[AW-1:0];
    end else if (cmd.shift_rd) begin
      ram_raddr = (op_q == ilst_pkg::OP_INSERT) ? ptr_dec[AW-1:0] : ptr_inc[AW-1:0];
    end
    ram_we    = cmd.shift_wr || cmd.write_value;
    ram_waddr = cmd.shift_wr ? ptr[AW-1:0] : idx_c[AW-1:0];
    ram_wdata = cmd.shift_wr ? ram_rdata : value_q;
  end

  ilst_ram #(
    .WIDTH (WORD_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // read word capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      rd <= ram_rdata;
    end
  end

  // count after the operation
  always_comb begin
    count_new = count;
    if (status_c == ilst_pkg::ST_OK) begin
      case (op_q)
        ilst_pkg::OP_INSERT: count_new = count + CNTW'(1);
        ilst_pkg::OP_REMOVE: count_new = cnt_m1;
        ilst_pkg::OP_POP:    count_new = cnt_m1;
        ilst_pkg::OP_CLEAR:  count_new = '0;
        default:             count_new = count;
      endcase
    end
  end

  assign has_read = (status_c == ilst_pkg::ST_OK) &&
                    (op_q == ilst_pkg::OP_REMOVE || op_q == ilst_pkg::OP_GET ||
                     op_q == ilst_pkg::OP_POP);
  assign rd_ext    = CW'(rd);
  assign count_out = OCW'(count_new);

  // live count register
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.finish) begin
      count <= count_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_read_value <= has_read ? rd_ext[ilst_pkg::VALUE_W-1:0] : '0;
      rsp_status     <= status_c;
      rsp_count      <= count_out[ilst_pkg::COUNT_W-1:0];
    end
  end

endmodule
`default_nettype wire

/* design/indexed_list_store_top.sv */
// Indexed list store: an ordered list of words kept in a ram of CAPACITY entries.
// Requests arrive on the request channel (op, index, value) with valid/ready;
// each accepted request yields exactly one result (read_value, status, count)
// on the result channel, in request order.
// The block works on one request at a time. After acceptance every request is
// checked, then goes through these steps before the result register loads:
//   get, pop, remove of the last entry: ram read, capture of the read word
//   set, insert at the end: write of the request word
//   clear, unused op, refused request: none
//   insert: one move per entry to shift, then the write; remove: read, capture,
//   then one move per entry to shift; each move is a ram read followed by a ram write
// Request ready returns high as the result register loads.
// The result register lets a new request enter while a result is still waiting;
// if the receiver stalls, the block finishes that next request and holds in its
// final step until the result register frees, with ready low.
// Reset clears the live count and the result valid and holds request ready low;
// ram contents are not cleared and only words of live entries are ever used.
`default_nettype none
module indexed_list_store_top #(
  parameter int CAPACITY   = 64,
  parameter int WORD_WIDTH = 32
) (
  input  wire logic  clk,
  input  wire logic  rst,
  ilst_req_if.sink   request,
  ilst_rsp_if.source result
);

  ilst_pkg::cmd_t  cmd;
  ilst_pkg::stat_t stat;
  logic            req_ready;

  assign request.ready = req_ready;

  ilst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ilst_dpath #(
    .CAPACITY   (CAPACITY),
    .WORD_WIDTH (WORD_WIDTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .req_op         (request.op),
    .req_index      (request.index),
    .req_value      (request.value),
    .rsp_valid      (result.valid),
    .rsp_ready      (result.ready),
    .rsp_read_value (result.read_value),
    .rsp_status     (result.status),
    .rsp_count      (result.count)
  );

endmodule
`default_nettype wire

/* tb/tb_indexed_list_store_top.sv */
// testbench for the indexed list store: random and directed requests checked against a predictor
`default_nettype none
module tb_indexed_list_store_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAPACITY    = 64;
  localparam int WORD_WIDTH  = 32;
  localparam int RANDOM_REQS = 500;

  // request mixes for the random phases
  typedef enum int {MIX_FILL, MIX_GROW, MIX_SHRINK, MIX_BLEND} req_mix_e;

  // one predicted result, tagged with the request that caused it
  typedef struct {
    int unsigned                   seq;
    logic [ilst_pkg::OP_W-1:0]     op;
    logic [ilst_pkg::INDEX_W-1:0]  index;
    logic [ilst_pkg::VALUE_W-1:0]  read_value;
    logic [ilst_pkg::STATUS_W-1:0] status;
    logic [ilst_pkg::COUNT_W-1:0]  count;
  } list_expect_t;

  // list predictor plus the queue of results still owed by the block
  class list_scoreboard;
    logic [WORD_WIDTH-1:0] words [CAPACITY];
    int unsigned           live_count;
    list_expect_t          owed_q[$];
    int unsigned           seq_num;
    int unsigned           mismatches;

    function new();
      foreach (words[i]) words[i] = '0;
      live_count = 0;
      seq_num    = 0;
      mismatches = 0;
    endfunction

    // apply an accepted request to the list and queue its result
    function void note_request(logic [ilst_pkg::OP_W-1:0] op,
                               logic [ilst_pkg::INDEX_W-1:0] index,
                               logic [ilst_pkg::VALUE_W-1:0] value);
      list_expect_t e;
      int           idx;
      idx          = int'(index);
      e.seq        = seq_num;
      e.op         = op;
      e.index      = index;
      e.read_value = '0;
      e.status     = ilst_pkg::ST_OK;
      seq_num++;
      case (op)
        ilst_pkg::OP_INSERT: begin
          // full is checked before the index
          if (live_count >= CAPACITY) begin
            e.status = ilst_pkg::ST_FULL;
          end else if (idx > live_count) begin
            e.status = ilst_pkg::ST_RANGE;
          end else begin
            for (int i = live_count; i > idx; i--) words[i] = words[i-1];
            words[idx] = value[WORD_WIDTH-1:0];
            live_count++;
          end
        end
        ilst_pkg::OP_REMOVE: begin
          if (idx >= live_count) begin
            e.status = ilst_pkg::ST_RANGE;
          end else begin
            e.read_value = ilst_pkg::VALUE_W'(words[idx]);
            for (int i = idx; i + 1 < live_count; i++) words[i] = words[i+1];
            live_count--;
          end
        end
        ilst_pkg::OP_GET: begin
          if (idx >= live_count) e.status = ilst_pkg::ST_RANGE;
          else e.read_value = ilst_pkg::VALUE_W'(words[idx]);
        end
        ilst_pkg::OP_SET: begin
          if (idx >= live_count) e.status = ilst_pkg::ST_RANGE;
          else words[idx] = value[WORD_WIDTH-1:0];
        end
        ilst_pkg::OP_POP: begin
          if (live_count == 0) begin
            e.status = ilst_pkg::ST_EMPTY;
          end else begin
            live_count--;
            e.read_value = ilst_pkg::VALUE_W'(words[live_count]);
          end
        end
        ilst_pkg::OP_CLEAR: begin
          live_count = 0;
        end
        default: begin
          // unused op codes leave everything alone
        end
      endcase
      e.count = ilst_pkg::COUNT_W'(live_count);
      owed_q.push_back(e);
    endfunction

    task report_mismatch(string what);
      $display("ERROR at %0t: %s", $time, what);
      mismatches++;
    endtask

    // compare one accepted result with the oldest owed one
    task check_result(logic [ilst_pkg::VALUE_W-1:0] rd,
                      logic [ilst_pkg::STATUS_W-1:0] st,
                      logic [ilst_pkg::COUNT_W-1:0] cnt);
      list_expect_t e;
      if (owed_q.size() == 0) begin
        report_mismatch($sformatf("unrequested result: read %h status %0d count %0d",
                                  rd, st, cnt));
        return;
      end
      e = owed_q.pop_front();
      if (rd !== e.read_value)
        report_mismatch($sformatf("request %0d op %0d index %0d: read %h, want %h",
                                  e.seq, e.op, e.index, rd, e.read_value));
      if (st !== e.status)
        report_mismatch($sformatf("request %0d op %0d index %0d: status %0d, want %0d",
                                  e.seq, e.op, e.index, st, e.status));
      if (cnt !== e.count)
        report_mismatch($sformatf("request %0d op %0d index %0d: count %0d, want %0d",
                                  e.seq, e.op, e.index, cnt, e.count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  ilst_req_if req_if();
  ilst_rsp_if rsp_if();

  indexed_list_store_top #(
    .CAPACITY  (CAPACITY),
    .WORD_WIDTH(WORD_WIDTH)
  ) u_top (
    .clk    (clk),
    .rst    (rst),
    .request(req_if),
    .result (rsp_if)
  );

  list_scoreboard list_sb = new();

  // sender burst shaping
  bit gaps_on    = 1'b1;
  int burst_left = 0;
  int random_sent = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && rsp_if.valid && rsp_if.ready)
      list_sb.check_result(rsp_if.read_value, rsp_if.status, rsp_if.count);
  end

  // receiver stall pattern, changing style every so often
  initial begin
    int style;
    int style_left;
    int phase;
    style      = 0;
    style_left = 0;
    phase      = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (style_left == 0) begin
        style      = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
        phase      = 0;
      end
      style_left--;
      case (style)
        0: rsp_if.ready = 1'b1;
        1: rsp_if.ready = 1'($urandom_range(0, 1));
        2: rsp_if.ready = ($urandom_range(0, 3) == 0);
        default: begin
          rsp_if.ready = ((phase % 9) >= 4);
          phase++;
        end
      endcase
    end
  end

  // drive one request from a falling edge until it is taken, end on a falling edge
  task automatic send_request(logic [ilst_pkg::OP_W-1:0] op,
                              logic [ilst_pkg::INDEX_W-1:0] index,
                              logic [ilst_pkg::VALUE_W-1:0] value);
    if (gaps_on && burst_left == 0) begin
      req_if.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    req_if.valid = 1'b1;
    req_if.op    = op;
    req_if.index = index;
    req_if.value = value;
    do @(posedge clk); while (!req_if.ready);
    list_sb.note_request(op, index, value);
    @(negedge clk);
  endtask

  // hold off until every owed result has come back
  task automatic wait_idle();
    req_if.valid = 1'b0;
    while (list_sb.owed_q.size() != 0) @(negedge clk);
  endtask

  // one random request shaped by the current mix
  task automatic random_request(req_mix_e mix);
    int w [7];
    int roll;
    int pick;
    int cnt;
    logic [ilst_pkg::OP_W-1:0]    op;
    logic [ilst_pkg::INDEX_W-1:0] index;
    logic [ilst_pkg::VALUE_W-1:0] value;
    // weights: insert, remove, get, set, pop, clear, unused
    case (mix)
      MIX_FILL:   w = '{85, 3, 5, 4, 3, 0, 0};
      MIX_GROW:   w = '{55, 10, 12, 10, 8, 1, 4};
      MIX_SHRINK: w = '{15, 35, 10, 8, 27, 2, 3};
      default:    w = '{30, 20, 18, 14, 12, 2, 4};
    endcase
    roll = $urandom_range(0, 99);
    pick = 0;
    while (pick < 6 && roll >= w[pick]) begin
      roll -= w[pick];
      pick++;
    end
    case (pick)
      0: op = ilst_pkg::OP_INSERT;
      1: op = ilst_pkg::OP_REMOVE;
      2: op = ilst_pkg::OP_GET;
      3: op = ilst_pkg::OP_SET;
      4: op = ilst_pkg::OP_POP;
      5: op = ilst_pkg::OP_CLEAR;
      default: op = ilst_pkg::OP_W'($urandom_range(6, 7));
    endcase
    cnt  = list_sb.live_count;
    roll = $urandom_range(0, 9);
    if (roll <= 6) begin
      if (op == ilst_pkg::OP_INSERT) index = ilst_pkg::INDEX_W'($urandom_range(0, cnt));
      else index = (cnt > 0) ? ilst_pkg::INDEX_W'($urandom_range(0, cnt - 1)) : '0;
    end else if (roll == 7) begin
      index = ilst_pkg::INDEX_W'(cnt);
    end else if (roll == 8) begin
      index = (cnt > 0) ? ilst_pkg::INDEX_W'(cnt - 1) : '0;
    end else begin
      index = ilst_pkg::INDEX_W'($urandom_range(0, 127));
    end
    roll = $urandom_range(0, 19);
    if (roll == 0) value = '0;
    else if (roll == 1) value = '1;
    else value = $urandom;
    send_request(op, index, value);
    random_sent++;
  endtask

  // stimulus
  initial begin
    int      phase_num;
    int      phase_len;
    int      spins;
    req_mix_e mix;
    req_if.valid = 1'b0;
    req_if.op    = ilst_pkg::OP_INSERT;
    req_if.index = '0;
    req_if.value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // directed: refusals on an empty list
    send_request(ilst_pkg::OP_POP,    7'd0,   32'h0);
    send_request(ilst_pkg::OP_GET,    7'd0,   32'h0);
    send_request(ilst_pkg::OP_REMOVE, 7'd0,   32'h0);
    send_request(ilst_pkg::OP_SET,    7'd0,   32'hFFFF_FFFF);
    send_request(ilst_pkg::OP_INSERT, 7'd1,   32'h1111_1111);
    // directed: inserts at front, end and middle with extreme words
    send_request(ilst_pkg::OP_INSERT, 7'd0,   32'h0000_0000);
    send_request(ilst_pkg::OP_INSERT, 7'd0,   32'hFFFF_FFFF);
    send_request(ilst_pkg::OP_INSERT, 7'd2,   32'hA5A5_A5A5);
    send_request(ilst_pkg::OP_INSERT, 7'd1,   32'h5A5A_5A5A);
    send_request(ilst_pkg::OP_GET,    7'd0,   32'h0);
    send_request(ilst_pkg::OP_GET,    7'd3,   32'h0);
    send_request(ilst_pkg::OP_SET,    7'd3,   32'h8000_0001);
    send_request(ilst_pkg::OP_GET,    7'd127, 32'hFFFF_FFFF);
    send_request(ilst_pkg::OP_INSERT, 7'd64,  32'h2222_2222);
    // directed: remove from the middle and the end, then pop
    send_request(ilst_pkg::OP_REMOVE, 7'd1,   32'h0);
    send_request(ilst_pkg::OP_REMOVE, 7'd2,   32'h0);
    send_request(ilst_pkg::OP_POP,    7'd0,   32'h0);
    // directed: unused op codes, then clear and use after clear
    send_request(3'd6,                7'd127, 32'hFFFF_FFFF);
    send_request(3'd7,                7'd0,   32'h0);
    send_request(ilst_pkg::OP_CLEAR,  7'd127, 32'hFFFF_FFFF);
    send_request(ilst_pkg::OP_GET,    7'd0,   32'h0);
    send_request(ilst_pkg::OP_POP,    7'd0,   32'h0);
    send_request(ilst_pkg::OP_INSERT, 7'd0,   32'h1234_5678);
    send_request(ilst_pkg::OP_GET,    7'd0,   32'h0);
    wait_idle();

    // random phases; the first one fills the store and pushes against full
    phase_num = 0;
    while (random_sent < RANDOM_REQS) begin
      gaps_on    = ($urandom_range(0, 9) >= 3);
      burst_left = 0;
      if (phase_num == 0) begin
        while (list_sb.live_count < CAPACITY) random_request(MIX_FILL);
        repeat (12) random_request(MIX_FILL);
      end else begin
        mix       = req_mix_e'($urandom_range(1, 3));
        phase_len = $urandom_range(60, 150);
        // keep the total close to the planned request count
        if (phase_len > RANDOM_REQS - random_sent) phase_len = RANDOM_REQS - random_sent;
        repeat (phase_len) random_request(mix);
      end
      if (phase_num == 0 || $urandom_range(0, 2) == 0) wait_idle();
      phase_num++;
    end
    req_if.valid = 1'b0;

    // drain, then a quiet stretch for anything stray
    spins = 0;
    while (list_sb.owed_q.size() != 0 && spins < 50000) begin
      @(posedge clk);
      spins++;
    end
    repeat (300) @(posedge clk);
    foreach (list_sb.owed_q[i])
      list_sb.report_mismatch($sformatf("request %0d op %0d never answered",
                                        list_sb.owed_q[i].seq, list_sb.owed_q[i].op));
    if (list_sb.mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
`default_nettype wire

/* files.f */
design/ilst_pkg.sv
design/ilst_req_if.sv
design/ilst_rsp_if.sv
design/ilst_ram.sv
design/ilst_ctrl.sv
design/ilst_dpath.sv
design/indexed_list_store_top.sv
tb/tb_indexed_list_store_top.sv
